// ===== hdl/amr_sfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package amr_sfd_pkg;

  localparam int unsigned TS_W = 42;
  localparam int unsigned NUM_W = 24;
  localparam int unsigned OFF_W = 32;
  localparam int unsigned SIZE_W = 6;
  localparam int unsigned MODE_W = 4;

  // 160 samples at 8 kHz in 100 ns ticks: 20 ms per frame
  localparam logic [TS_W-1:0] TICKS_PER_FRAME = TS_W'(10000000 * 160 / 8000);

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_FRAMES  = 2'd1,
    PH_STOPPED = 2'd2,
    PH_BADHDR  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FRAME      = 2'd0,
    KIND_SUMMARY    = 2'd1,
    KIND_BAD_HEADER = 2'd2,
    KIND_NO_FRAMES  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic               is_wideband;
    logic [MODE_W-1:0]  frame_mode;
    logic [SIZE_W-1:0]  frame_size;
    logic [OFF_W-1:0]   frame_offset;
    logic [NUM_W-1:0]   frame_number;
    logic [TS_W-1:0]    time_stamp;
    logic               last;
  } result_t;

  function automatic logic [SIZE_W-1:0] nb_size(input logic [MODE_W-1:0] mode);
    logic [SIZE_W-1:0] s;
    unique case (mode)
      4'd0:    s = 6'd13;
      4'd1:    s = 6'd14;
      4'd2:    s = 6'd16;
      4'd3:    s = 6'd18;
      4'd4:    s = 6'd20;
      4'd5:    s = 6'd21;
      4'd6:    s = 6'd27;
      4'd7:    s = 6'd32;
      4'd8:    s = 6'd6;
      default: s = 6'd1;
    endcase
    return s;
  endfunction

  function automatic logic [SIZE_W-1:0] wb_size(input logic [MODE_W-1:0] mode);
    logic [SIZE_W-1:0] s;
    unique case (mode)
      4'd0:    s = 6'd18;
      4'd1:    s = 6'd24;
      4'd2:    s = 6'd33;
      4'd3:    s = 6'd37;
      4'd4:    s = 6'd41;
      4'd5:    s = 6'd47;
      4'd6:    s = 6'd51;
      4'd7:    s = 6'd59;
      4'd8:    s = 6'd61;
      4'd9:    s = 6'd6;
      4'd10:   s = 6'd6;
      4'd11:   s = 6'd0;
      4'd12:   s = 6'd0;
      4'd13:   s = 6'd0;
      default: s = 6'd1;
    endcase
    return s;
  endfunction

  // "#!AMR-WB\n"; byte 5 is also checked for '\n' (narrowband) by the caller
  function automatic logic [7:0] wb_magic(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h23;
      4'd1:    c = 8'h21;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h4D;
      4'd4:    c = 8'h52;
      4'd5:    c = 8'h2D;
      4'd6:    c = 8'h57;
      4'd7:    c = 8'h42;
      4'd8:    c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/amr_storage_frame_delimiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Results of an accepted byte are registered into the output FIFO.
// Throughput: one byte per cycle unless the input stalls; the parse state updates once per
// accepted byte. Results leave through a 4-entry output FIFO, one per cycle unless the
// receiver stalls; input stalls when fewer than two FIFO slots are free. Reset (async,
// active low) clears the parser to header matching and empties the FIFO.

module amr_storage_frame_delimiter #(
  parameter int unsigned OFFSET_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH  = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_stream_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic             is_wideband_o,
  output logic [3:0]       frame_mode_o,
  output logic [5:0]       frame_size_o,
  output logic [31:0]      frame_offset_o,
  output logic [23:0]      frame_number_o,
  output logic [41:0]      time_stamp_o,
  output logic             last_o
);

  localparam int unsigned PtrW = $clog2(amr_sfd_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = PtrW + 1;
  localparam int unsigned SizeW = amr_sfd_pkg::SIZE_W;
  localparam int unsigned ModeW = amr_sfd_pkg::MODE_W;
  localparam int unsigned TsW = amr_sfd_pkg::TS_W;

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  amr_sfd_pkg::phase_e     phase_q, phase_s;
  logic                    wb_q, wb_s;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_s;
  logic [OFFSET_WIDTH-1:0] start_q, start_s;
  logic [SizeW-1:0]        left_q, left_s;
  logic [ModeW-1:0]        mode_q, mode_s;
  logic [SizeW-1:0]        size_q, size_s;
  logic [COUNT_WIDTH-1:0]  cnt_q, cnt_s;
  logic [TsW-1:0]          ts_q, ts_s;     // always cnt_q * TICKS_PER_FRAME, mod 2^42
  logic                    hfull_q, hfull_s;  // at least 9 bytes seen

  logic                    frame_done;
  logic [ModeW-1:0]        toc_mode;
  logic [SizeW-1:0]        toc_size;

  logic in_accept;
  logic out_accept;

  assign in_accept  = in_valid_i && !in_stall_o;

  // Stepped state for one byte, before the end-of-stream reset
  always_comb begin
    phase_s    = phase_q;
    wb_s       = wb_q;
    start_s    = start_q;
    left_s     = left_q;
    mode_s     = mode_q;
    size_s     = size_q;
    cnt_s      = cnt_q;
    ts_s       = ts_q;
    frame_done = 1'b0;
    toc_mode   = data_byte_i[6:3];
    toc_size   = wb_q ? amr_sfd_pkg::wb_size(toc_mode) : amr_sfd_pkg::nb_size(toc_mode);

    unique case (phase_q)
      amr_sfd_pkg::PH_HEADER: begin
        if (pos_q == OFFSET_WIDTH'(5)) begin
          // narrowband magic ends here with '\n'; wideband continues with '-'
          if (data_byte_i == 8'h0A) begin
            phase_s = amr_sfd_pkg::PH_FRAMES;
          end else if (data_byte_i != 8'h2D) begin
            phase_s = amr_sfd_pkg::PH_BADHDR;
          end
        end else if (pos_q < OFFSET_WIDTH'(9) &&
                     data_byte_i == amr_sfd_pkg::wb_magic(pos_q[3:0])) begin
          if (pos_q == OFFSET_WIDTH'(8)) begin
            wb_s    = 1'b1;
            phase_s = amr_sfd_pkg::PH_FRAMES;
          end
        end else begin
          phase_s = amr_sfd_pkg::PH_BADHDR;
        end
      end
      amr_sfd_pkg::PH_FRAMES: begin
        if (left_q == '0) begin
          // table-of-contents byte
          if (toc_size == '0) begin
            phase_s = amr_sfd_pkg::PH_STOPPED;
          end else if (toc_size != SizeW'(1)) begin
            start_s = pos_q;
            mode_s  = toc_mode;
            size_s  = toc_size;
            left_s  = toc_size - SizeW'(1);
          end
        end else begin
          left_s = left_q - SizeW'(1);
          if (left_q == SizeW'(1)) begin
            frame_done = 1'b1;
            cnt_s      = cnt_q + COUNT_WIDTH'(1);
            ts_s       = (cnt_s == '0) ? '0 : ts_q + amr_sfd_pkg::TICKS_PER_FRAME;
          end
        end
      end
      amr_sfd_pkg::PH_STOPPED: begin
      end
      amr_sfd_pkg::PH_BADHDR: begin
      end
    endcase

    pos_s   = pos_q + OFFSET_WIDTH'(1);
    hfull_s = hfull_q || (pos_q == OFFSET_WIDTH'(8));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= amr_sfd_pkg::PH_HEADER;
      wb_q    <= 1'b0;
      pos_q   <= '0;
      start_q <= '0;
      left_q  <= '0;
      mode_q  <= '0;
      size_q  <= '0;
      cnt_q   <= '0;
      ts_q    <= '0;
      hfull_q <= 1'b0;
    end else if (in_accept) begin
      if (end_of_stream_i) begin
        // a new stream starts with the next byte
        phase_q <= amr_sfd_pkg::PH_HEADER;
        wb_q    <= 1'b0;
        pos_q   <= '0;
        start_q <= '0;
        left_q  <= '0;
        mode_q  <= '0;
        size_q  <= '0;
        cnt_q   <= '0;
        ts_q    <= '0;
        hfull_q <= 1'b0;
      end else begin
        phase_q <= phase_s;
        wb_q    <= wb_s;
        pos_q   <= pos_s;
        start_q <= start_s;
        left_q  <= left_s;
        mode_q  <= mode_s;
        size_q  <= size_s;
        cnt_q   <= cnt_s;
        ts_q    <= ts_s;
        hfull_q <= hfull_s;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result generation: frame result first, then the end-of-stream summary
  // ---------------------------------------------------------------------------
  amr_sfd_pkg::result_t frame_res, summ_res, res_a, res_b;
  logic [1:0]           n_res;

  always_comb begin
    frame_res              = '0;
    frame_res.kind         = amr_sfd_pkg::KIND_FRAME;
    frame_res.is_wideband  = wb_q;
    frame_res.frame_mode   = mode_q;
    frame_res.frame_size   = size_q;
    frame_res.frame_offset = amr_sfd_pkg::OFF_W'(start_q);
    frame_res.frame_number = amr_sfd_pkg::NUM_W'(cnt_q);
    frame_res.time_stamp   = ts_q;
    frame_res.last         = !end_of_stream_i;

    summ_res      = '0;
    summ_res.last = 1'b1;
    if (phase_s == amr_sfd_pkg::PH_HEADER || phase_s == amr_sfd_pkg::PH_BADHDR ||
        !hfull_s) begin
      summ_res.kind = amr_sfd_pkg::KIND_BAD_HEADER;
    end else if (cnt_s == '0) begin
      summ_res.kind        = amr_sfd_pkg::KIND_NO_FRAMES;
      summ_res.is_wideband = wb_s;
    end else begin
      summ_res.kind         = amr_sfd_pkg::KIND_SUMMARY;
      summ_res.is_wideband  = wb_s;
      summ_res.frame_number = amr_sfd_pkg::NUM_W'(cnt_s);
      summ_res.time_stamp   = ts_s;
    end

    res_a = frame_done ? frame_res : summ_res;
    res_b = summ_res;
    n_res = 2'({1'b0, frame_done} + {1'b0, end_of_stream_i});
  end

  // ---------------------------------------------------------------------------
  // Output FIFO
  // ---------------------------------------------------------------------------
  amr_sfd_pkg::result_t fifo_q [amr_sfd_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      fcnt_q;
  logic [1:0]           n_wr;
  amr_sfd_pkg::result_t head;

  assign n_wr       = in_accept ? n_res : 2'd0;
  assign out_accept = out_valid_o && !out_stall_i;
  // room for two results must be guaranteed before taking a byte
  assign in_stall_o = fcnt_q > CntW'(amr_sfd_pkg::FIFO_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      fifo_q[wr_ptr_q] <= res_a;
    end
    if (n_wr == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_wr);
      rd_ptr_q <= rd_ptr_q + PtrW'(out_accept);
      fcnt_q   <= fcnt_q + CntW'(n_wr) - CntW'(out_accept);
    end
  end

  assign head           = fifo_q[rd_ptr_q];
  assign out_valid_o    = fcnt_q != '0;
  assign kind_o         = head.kind;
  assign is_wideband_o  = head.is_wideband;
  assign frame_mode_o   = head.frame_mode;
  assign frame_size_o   = head.frame_size;
  assign frame_offset_o = head.frame_offset;
  assign frame_number_o = head.frame_number;
  assign time_stamp_o   = head.time_stamp;
  assign last_o         = head.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CntW'(amr_sfd_pkg::FIFO_DEPTH))
    else $error("output FIFO overflow");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> fcnt_q <= CntW'(amr_sfd_pkg::FIFO_DEPTH - 2))
    else $error("byte taken without room for two results");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q < size_q || left_q == '0)
    else $error("remaining byte count exceeds frame size");

  a_eos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && end_of_stream_i |=>
      phase_q == amr_sfd_pkg::PH_HEADER && pos_q == '0 && cnt_q == '0)
    else $error("parser not restarted after end of stream");

  a_ts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> ts_q == '0)
    else $error("time accumulator out of step with frame count");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // Frame delimiter testbench: drives byte items into the parser, predicts the
  // frame/summary results in a local parser model (typed directed items carry hand-written
  // ones) and checks the DUT output stream field by field, in order.

  localparam int unsigned N_DIRECTED   = 25;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;

  localparam logic [7:0] LF   = 8'h0A;
  localparam logic [7:0] DASH = 8'h2D;

  // storage magic "#!AMR-WB\n"; narrowband takes LF in place of the dash
  localparam logic [7:0] MAGIC [9] = '{8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h2D,
                                       8'h57, 8'h42, 8'h0A};

  // frame bytes per mode, TOC byte included; 1 = no-data, 0 = stop parsing
  localparam logic [5:0] NB_BYTES [16] = '{6'd13, 6'd14, 6'd16, 6'd18, 6'd20, 6'd21,
                                           6'd27, 6'd32, 6'd6, 6'd1, 6'd1, 6'd1,
                                           6'd1, 6'd1, 6'd1, 6'd1};
  localparam logic [5:0] WB_BYTES [16] = '{6'd18, 6'd24, 6'd33, 6'd37, 6'd41, 6'd47,
                                           6'd51, 6'd59, 6'd61, 6'd6, 6'd6, 6'd0,
                                           6'd0, 6'd0, 6'd1, 6'd1};

  // hand-written results for the directed table
  localparam amr_sfd_pkg::result_t R_NONE = amr_sfd_pkg::result_t'(
    {amr_sfd_pkg::KIND_FRAME, 1'b0, 4'd0, 6'd0, 32'd0, 24'd0, 42'd0, 1'b0});
  localparam amr_sfd_pkg::result_t R_BAD_HEADER = amr_sfd_pkg::result_t'(
    {amr_sfd_pkg::KIND_BAD_HEADER, 1'b0, 4'd0, 6'd0, 32'd0, 24'd0, 42'd0, 1'b1});
  localparam amr_sfd_pkg::result_t R_NO_FRAMES_WB = amr_sfd_pkg::result_t'(
    {amr_sfd_pkg::KIND_NO_FRAMES, 1'b1, 4'd0, 6'd0, 32'd0, 24'd0, 42'd0, 1'b1});

  typedef struct packed {
    logic [7:0]           data;
    logic                 eos;
    logic                 typed;   // 1: res below is the expected result, else predicted
    amr_sfd_pkg::result_t res;
  } step_t;

  // Directed items: short header, bad magic at the byte extreme, wideband
  // stream stopped by a size-zero mode, narrowband frame ending on the final
  // byte (frame result followed by the summary).
  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{8'h23, 1'b0, 1'b0, R_NONE},
    '{8'h21, 1'b1, 1'b1, R_BAD_HEADER},
    '{8'hFF, 1'b1, 1'b1, R_BAD_HEADER},
    '{8'h23, 1'b0, 1'b0, R_NONE},
    '{8'h21, 1'b0, 1'b0, R_NONE},
    '{8'h41, 1'b0, 1'b0, R_NONE},
    '{8'h4D, 1'b0, 1'b0, R_NONE},
    '{8'h52, 1'b0, 1'b0, R_NONE},
    '{8'h2D, 1'b0, 1'b0, R_NONE},
    '{8'h57, 1'b0, 1'b0, R_NONE},
    '{8'h42, 1'b0, 1'b0, R_NONE},
    '{8'h0A, 1'b0, 1'b0, R_NONE},
    '{8'h58, 1'b1, 1'b1, R_NO_FRAMES_WB},
    '{8'h23, 1'b0, 1'b0, R_NONE},
    '{8'h21, 1'b0, 1'b0, R_NONE},
    '{8'h41, 1'b0, 1'b0, R_NONE},
    '{8'h4D, 1'b0, 1'b0, R_NONE},
    '{8'h52, 1'b0, 1'b0, R_NONE},
    '{8'h0A, 1'b0, 1'b0, R_NONE},
    '{8'h40, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b0, 1'b0, R_NONE},
    '{8'hFF, 1'b0, 1'b0, R_NONE},
    '{8'h55, 1'b0, 1'b0, R_NONE},
    '{8'hAA, 1'b0, 1'b0, R_NONE},
    '{8'h00, 1'b1, 1'b0, R_NONE}
  };

  // DUT signals; every input known from time zero
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in   = 8'h00;
  logic        eos_in    = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic        is_wideband;
  logic [3:0]  frame_mode;
  logic [5:0]  frame_size;
  logic [31:0] frame_offset;
  logic [23:0] frame_number;
  logic [41:0] time_stamp;
  logic        last;

  // idle rates in percent, set per phase of the run
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned mismatch_cnt = 0;

  amr_sfd_pkg::result_t frame_records_due [$];

  // parser model state
  amr_sfd_pkg::phase_e st_phase;
  logic        st_wb;
  logic [31:0] st_pos;
  logic [31:0] st_start;
  logic [5:0]  st_left;
  logic [3:0]  st_mode;
  logic [5:0]  st_size;
  logic [23:0] st_count;
  logic        st_full;   // nine bytes seen in this stream

  amr_storage_frame_delimiter uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (byte_in),
    .end_of_stream_i (eos_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .is_wideband_o   (is_wideband),
    .frame_mode_o    (frame_mode),
    .frame_size_o    (frame_size),
    .frame_offset_o  (frame_offset),
    .frame_number_o  (frame_number),
    .time_stamp_o    (time_stamp),
    .last_o          (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void clear_parser();
    st_phase = amr_sfd_pkg::PH_HEADER;
    st_wb    = 1'b0;
    st_pos   = '0;
    st_start = '0;
    st_left  = '0;
    st_mode  = '0;
    st_size  = '0;
    st_count = '0;
    st_full  = 1'b0;
  endfunction

  // Advance the parser model by one byte and queue the results it causes.
  function automatic void delimit_byte(input logic [7:0] b, input logic eos);
    int n0;
    logic [3:0] mode;
    logic [5:0] size;
    amr_sfd_pkg::result_t r;
    n0 = frame_records_due.size();
    case (st_phase)
      amr_sfd_pkg::PH_HEADER: begin
        if (st_pos == 32'd5) begin
          // '\n' ends a narrowband header, '-' continues toward wideband
          if (b == LF) st_phase = amr_sfd_pkg::PH_FRAMES;
          else if (b != DASH) st_phase = amr_sfd_pkg::PH_BADHDR;
        end else if (st_pos < 32'd9) begin
          if (b == MAGIC[st_pos[3:0]]) begin
            if (st_pos == 32'd8) begin
              st_wb    = 1'b1;
              st_phase = amr_sfd_pkg::PH_FRAMES;
            end
          end else begin
            st_phase = amr_sfd_pkg::PH_BADHDR;
          end
        end else begin
          st_phase = amr_sfd_pkg::PH_BADHDR;
        end
      end
      amr_sfd_pkg::PH_FRAMES: begin
        if (st_left == 6'd0) begin
          // TOC byte: mode in bits 6..3
          mode = b[6:3];
          size = st_wb ? WB_BYTES[mode] : NB_BYTES[mode];
          if (size == 6'd0) begin
            st_phase = amr_sfd_pkg::PH_STOPPED;
          end else if (size != 6'd1) begin
            st_start = st_pos;
            st_mode  = mode;
            st_size  = size;
            st_left  = size - 6'd1;
          end
        end else begin
          st_left = st_left - 6'd1;
          if (st_left == 6'd0) begin
            r = amr_sfd_pkg::result_t'({amr_sfd_pkg::KIND_FRAME, st_wb, st_mode, st_size,
                  st_start, st_count,
                  amr_sfd_pkg::TS_W'(st_count) * amr_sfd_pkg::TICKS_PER_FRAME, 1'b0});
            frame_records_due.push_back(r);
            st_count = st_count + 24'd1;
          end
        end
      end
      default: ;
    endcase

    if (st_pos == 32'd8) st_full = 1'b1;
    st_pos = st_pos + 32'd1;

    if (eos) begin
      if (st_phase == amr_sfd_pkg::PH_HEADER || st_phase == amr_sfd_pkg::PH_BADHDR ||
          !st_full)
        r = R_BAD_HEADER;
      else if (st_count == 24'd0)
        r = amr_sfd_pkg::result_t'({amr_sfd_pkg::KIND_NO_FRAMES, st_wb, 4'd0, 6'd0,
                                    32'd0, 24'd0, 42'd0, 1'b0});
      else
        r = amr_sfd_pkg::result_t'({amr_sfd_pkg::KIND_SUMMARY, st_wb, 4'd0, 6'd0,
              32'd0, st_count,
              amr_sfd_pkg::TS_W'(st_count) * amr_sfd_pkg::TICKS_PER_FRAME, 1'b0});
      frame_records_due.push_back(r);
      clear_parser();
    end

    if (frame_records_due.size() > n0)
      frame_records_due[frame_records_due.size() - 1].last = 1'b1;
  endfunction

  // Offer one byte item; predict once it is taken.
  task automatic feed_byte(input logic [7:0] b, input logic eos, input logic typed,
                           input amr_sfd_pkg::result_t fixed);
    int n0;
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    eos_in   <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n0 = frame_records_due.size();
    delimit_byte(b, eos);
    if (typed) begin
      while (frame_records_due.size() > n0) void'(frame_records_due.pop_back());
      frame_records_due.push_back(fixed);
    end
    items_sent++;
  endtask

  // One stream: mostly well-formed files with random frames, some with a
  // corrupted header, some plain noise. The final byte carries end of stream.
  task automatic random_stream();
    logic [7:0] bytes_q [$];
    int unsigned pick, n_frames, len, sel;
    logic wb;
    logic [3:0] mode;
    logic [5:0] size;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      wb = 1'($urandom_range(0, 1));
      if (wb) begin
        for (int i = 0; i < 9; i++) bytes_q.push_back(MAGIC[4'(i)]);
      end else begin
        for (int i = 0; i < 5; i++) bytes_q.push_back(MAGIC[4'(i)]);
        bytes_q.push_back(LF);
      end
      if (pick >= 70)
        bytes_q[$urandom_range(0, bytes_q.size() - 1)] = 8'($urandom_range(0, 255));
      n_frames = $urandom_range(0, 4);
      for (int f = 0; f < n_frames; f++) begin
        sel = $urandom_range(0, 99);
        if (sel < 75)      mode = wb ? 4'($urandom_range(0, 10)) : 4'($urandom_range(0, 8));
        else if (sel < 92) mode = wb ? 4'($urandom_range(14, 15)) : 4'($urandom_range(9, 15));
        else               mode = 4'($urandom_range(0, 15));
        // unused TOC bits random
        bytes_q.push_back({1'($urandom_range(0, 1)), mode, 3'($urandom_range(0, 7))});
        size = wb ? WB_BYTES[mode] : NB_BYTES[mode];
        if (size == 6'd0) begin
          // stopped: trailing bytes are ignored
          repeat ($urandom_range(0, 3)) bytes_q.push_back(8'($urandom_range(0, 255)));
          break;
        end
        if (size > 6'd1) begin
          len = size - 1;
          // truncated last frame now and then
          if (f == n_frames - 1 && $urandom_range(0, 5) == 0)
            len = $urandom_range(0, size - 2);
          repeat (len) bytes_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    end else begin
      repeat ($urandom_range(1, 12)) bytes_q.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < bytes_q.size(); i++)
      feed_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, R_NONE);
  endtask

  function automatic string fmt_record(input amr_sfd_pkg::result_t r);
    return $sformatf("kind=%0d wb=%0d mode=%0d size=%0d off=%0d num=%0d ts=%0d last=%0d",
                     r.kind, r.is_wideband, r.frame_mode, r.frame_size, r.frame_offset,
                     r.frame_number, r.time_stamp, r.last);
  endfunction

  // receiver back-pressure, changed at the falling edge
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    amr_sfd_pkg::result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = amr_sfd_pkg::result_t'({kind, is_wideband, frame_mode, frame_size,
                                    frame_offset, frame_number, time_stamp, last});
      if (frame_records_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result: %s", fmt_record(got));
      end else begin
        want = frame_records_due.pop_front();
        if (got.kind !== want.kind || got.is_wideband !== want.is_wideband ||
            got.frame_mode !== want.frame_mode || got.frame_size !== want.frame_size ||
            got.frame_offset !== want.frame_offset ||
            got.frame_number !== want.frame_number ||
            got.time_stamp !== want.time_stamp || got.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch expected: %s", fmt_record(want));
            $display("         actual:   %s", fmt_record(got));
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned quarter;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    for (int i = 0; i < N_DIRECTED; i++)
      feed_byte(DIRECTED[5'(i)].data, DIRECTED[5'(i)].eos, DIRECTED[5'(i)].typed,
                DIRECTED[5'(i)].res);

    // random streams in four idling phases: none, sender, receiver, both
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quarter = items_sent * 4 / RANDOM_ITEMS;
      case (quarter)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 69; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 69; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      random_stream();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (frame_records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && frame_records_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
